// ===== rtl/core/rdz_pkg.sv =====
// rdz_pkg: shared types, register codes and pipeline step functions
// for the radial dead-zone scaler. No dependencies.
package rdz_pkg;

   localparam int SQ_STEPS  = 16;  // one root bit per stage
   localparam int DIV_STEPS = 16;  // one quotient bit per stage

   localparam logic [14:0] DEAD_ZONE_RESET  = 15'd8000;
   localparam logic [15:0] FULL_SCALE_RESET = 16'd30000;
   localparam logic [31:0] LEN_MAX          = 32'd46341;
   localparam logic [15:0] Q_MAX            = 16'd32768;

   typedef enum logic {
      REG_DEAD_ZONE  = 1'b0,
      REG_FULL_SCALE = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic signed [15:0] axis_x;
      logic signed [15:0] axis_y;
   } req_type;

   typedef struct packed {
      logic signed [15:0] scaled_x;
      logic signed [15:0] scaled_y;
      logic               inside_dead_zone;
   } rsp_type;

   // square-root pipeline word
   typedef struct packed {
      logic        neg_x;
      logic        neg_y;
      logic [15:0] mag_x;
      logic [15:0] mag_y;
      logic [31:0] v;
      logic [31:0] root;
   } sqs_type;

   // gain stage word
   typedef struct packed {
      logic        neg_x;
      logic        neg_y;
      logic [15:0] mag_x;
      logic [15:0] mag_y;
      logic [15:0] len;
      logic        in_dz;
      logic        zero;
      logic        unity;
      logic [15:0] num;
      logic [15:0] den;
   } gain_type;

   // divider pipeline word
   typedef struct packed {
      logic        neg_x;
      logic        neg_y;
      logic        in_dz;
      logic        zero;
      logic [31:0] d;
      logic [47:0] rx;
      logic [47:0] ry;
      logic [15:0] qx;
      logic [15:0] qy;
   } dvs_type;

   // one digit of the bitwise integer square root
   function automatic sqs_type sqrt_step(input sqs_type s, input int k);
      sqs_type     r;
      logic [31:0] bit_w;
      logic [31:0] trial;
      r     = s;
      bit_w = 32'd1 << (30 - 2 * k);
      trial = s.root + bit_w;
      if (s.v >= trial) begin
         r.v    = s.v - trial;
         r.root = (s.root >> 1) + bit_w;
      end else begin
         r.root = s.root >> 1;
      end
      return r;
   endfunction

   // one quotient bit of the restoring divider, both axes
   function automatic dvs_type div_step(input dvs_type s, input int k);
      dvs_type     r;
      logic [47:0] dsh;
      r   = s;
      dsh = 48'(s.d) << (DIV_STEPS - 1 - k);
      if (s.rx >= dsh) begin
         r.rx = s.rx - dsh;
         r.qx[DIV_STEPS - 1 - k] = 1'b1;
      end
      if (s.ry >= dsh) begin
         r.ry = s.ry - dsh;
         r.qy[DIV_STEPS - 1 - k] = 1'b1;
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/radial_dead_zone_scaler.sv =====
// radial_dead_zone_scaler: top level, pipelined radial dead zone with gain.
// Depends on rdz_pkg.
//
// Usage: one stick sample (axis_x, axis_y) enters per req beat; one result
// (scaled_x, scaled_y in Q1.15, inside_dead_zone) leaves per rsp beat, in
// order. Both channels are valid/ready.
// Throughput: one sample per cycle while the output is not stalled; the
// pipeline is a square stage, a sum stage, 16 square-root stages (one root
// bit each), two gain stages, 16 divider stages (one quotient bit each for
// both axes) and the output register.
// Config: APB-style port, dead_zone at 0x0, full_scale at 0x4; write only
// while the block is empty.
// Reset: synchronous, clears all valid bits and loads dead_zone = 8000,
// full_scale = 30000.
// Stall: when the output register holds a beat that is not taken, the
// whole pipeline holds and req_ready drops; nothing is lost or repeated.
module radial_dead_zone_scaler
   import rdz_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_payload,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_payload,
   // config port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [14:0] dead_zone_ff;
   logic [15:0] full_scale_ff;
   reg_index_type reg_sel;

   logic pipe_en;

   logic     a_vld_ff;
   logic     a_neg_x_ff, a_neg_y_ff;
   logic [15:0] a_mag_x_ff, a_mag_y_ff;
   logic [31:0] a_sqx_ff, a_sqy_ff;
   logic [15:0] mag_x_in, mag_y_in;

   sqs_type sq_ff  [0:SQ_STEPS];
   sqs_type sq_in  [0:SQ_STEPS];
   logic    sq_vld_ff [0:SQ_STEPS];

   gain_type g_ff, g_in;
   logic     g_vld_ff;

   dvs_type dv_ff [0:DIV_STEPS];
   dvs_type dv_in [0:DIV_STEPS];
   logic    dv_vld_ff [0:DIV_STEPS];

   logic    rsp_valid_ff;
   rsp_type rsp_ff, rsp_in;

   logic [15:0] n_sel;

   // config registers
   assign pready  = 1'b1;
   assign reg_sel = reg_index_type'(paddr[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         dead_zone_ff  <= DEAD_ZONE_RESET;
         full_scale_ff <= FULL_SCALE_RESET;
      end else if (psel && penable && pwrite && pready) begin
         case (reg_sel)
            REG_DEAD_ZONE:  dead_zone_ff  <= pwdata[14:0];
            REG_FULL_SCALE: full_scale_ff <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_DEAD_ZONE:  prdata = {17'd0, dead_zone_ff};
         REG_FULL_SCALE: prdata = {16'd0, full_scale_ff};
         default:        prdata = 32'd0;
      endcase
   end

   // global advance: hold everything while the output beat waits
   assign pipe_en   = !rsp_valid_ff || rsp_ready;
   assign req_ready = pipe_en && !reset;

   // magnitudes of the inputs
   assign mag_x_in = req_payload.axis_x[15] ? 16'(~req_payload.axis_x + 16'd1)
                                             : 16'(req_payload.axis_x);
   assign mag_y_in = req_payload.axis_y[15] ? 16'(~req_payload.axis_y + 16'd1)
                                             : 16'(req_payload.axis_y);

   // square-root step chain
   always_comb begin
      sq_in[0].neg_x = a_neg_x_ff;
      sq_in[0].neg_y = a_neg_y_ff;
      sq_in[0].mag_x = a_mag_x_ff;
      sq_in[0].mag_y = a_mag_y_ff;
      sq_in[0].v     = a_sqx_ff + a_sqy_ff;
      sq_in[0].root  = 32'd0;
      for (int k = 0; k < SQ_STEPS; k++) begin
         sq_in[k + 1] = sqrt_step(sq_ff[k], k);
      end
   end

   // gain terms from the length
   always_comb begin
      g_in.neg_x  = sq_ff[SQ_STEPS].neg_x;
      g_in.neg_y  = sq_ff[SQ_STEPS].neg_y;
      g_in.mag_x  = sq_ff[SQ_STEPS].mag_x;
      g_in.mag_y  = sq_ff[SQ_STEPS].mag_y;
      g_in.len    = sq_ff[SQ_STEPS].root[15:0];
      g_in.in_dz  = g_in.len < {1'b0, dead_zone_ff};
      g_in.zero   = g_in.len == 16'd0;
      g_in.num    = g_in.len - {1'b0, dead_zone_ff};
      g_in.den    = full_scale_ff - {1'b0, dead_zone_ff};
      g_in.unity  = (full_scale_ff <= {1'b0, dead_zone_ff}) || (g_in.num >= g_in.den);
   end

   // divider operands and quotient bit chain
   assign n_sel = g_ff.unity ? 16'd1 : g_ff.num;

   always_comb begin
      dv_in[0].neg_x  = g_ff.neg_x;
      dv_in[0].neg_y  = g_ff.neg_y;
      dv_in[0].in_dz  = g_ff.in_dz;
      dv_in[0].zero   = g_ff.zero;
      dv_in[0].d      = g_ff.unity ? {16'd0, g_ff.len} : g_ff.den * g_ff.len;
      dv_in[0].rx     = {1'b0, 32'(g_ff.mag_x * n_sel), 15'd0};
      dv_in[0].ry     = {1'b0, 32'(g_ff.mag_y * n_sel), 15'd0};
      dv_in[0].qx     = 16'd0;
      dv_in[0].qy     = 16'd0;
      for (int k = 0; k < DIV_STEPS; k++) begin
         dv_in[k + 1] = div_step(dv_ff[k], k);
      end
   end

   // sign, saturation and dead-zone forcing
   always_comb begin
      rsp_in.inside_dead_zone = dv_ff[DIV_STEPS].in_dz;
      if (dv_ff[DIV_STEPS].in_dz || dv_ff[DIV_STEPS].zero) begin
         rsp_in.scaled_x = 16'sd0;
         rsp_in.scaled_y = 16'sd0;
      end else begin
         if (dv_ff[DIV_STEPS].neg_x)
            rsp_in.scaled_x = signed'(16'(16'd0 - dv_ff[DIV_STEPS].qx));
         else
            rsp_in.scaled_x = signed'(dv_ff[DIV_STEPS].qx[15] ? 16'h7FFF
                                                             : dv_ff[DIV_STEPS].qx);
         if (dv_ff[DIV_STEPS].neg_y)
            rsp_in.scaled_y = signed'(16'(16'd0 - dv_ff[DIV_STEPS].qy));
         else
            rsp_in.scaled_y = signed'(dv_ff[DIV_STEPS].qy[15] ? 16'h7FFF
                                                             : dv_ff[DIV_STEPS].qy);
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff     <= 1'b0;
         g_vld_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k <= SQ_STEPS; k++) sq_vld_ff[k] <= 1'b0;
         for (int k = 0; k <= DIV_STEPS; k++) dv_vld_ff[k] <= 1'b0;
      end else if (pipe_en) begin
         a_vld_ff     <= req_valid;
         sq_vld_ff[0] <= a_vld_ff;
         for (int k = 0; k < SQ_STEPS; k++) sq_vld_ff[k + 1] <= sq_vld_ff[k];
         g_vld_ff     <= sq_vld_ff[SQ_STEPS];
         dv_vld_ff[0] <= g_vld_ff;
         for (int k = 0; k < DIV_STEPS; k++) dv_vld_ff[k + 1] <= dv_vld_ff[k];
         rsp_valid_ff <= dv_vld_ff[DIV_STEPS];
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         a_neg_x_ff <= req_payload.axis_x[15];
         a_neg_y_ff <= req_payload.axis_y[15];
         a_mag_x_ff <= mag_x_in;
         a_mag_y_ff <= mag_y_in;
         a_sqx_ff   <= mag_x_in * mag_x_in;
         a_sqy_ff   <= mag_y_in * mag_y_in;
         for (int k = 0; k <= SQ_STEPS; k++) sq_ff[k] <= sq_in[k];
         g_ff <= g_in;
         for (int k = 0; k <= DIV_STEPS; k++) dv_ff[k] <= dv_in[k];
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // dead-zone beats carry zero deflection
   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.inside_dead_zone |->
         rsp_ff.scaled_x == 16'sd0 && rsp_ff.scaled_y == 16'sd0)
      else $error("dead-zone beat with nonzero output");

   // root never exceeds the largest possible length
   a_root_range: assert property (@(posedge clock) disable iff (reset)
      sq_vld_ff[SQ_STEPS] |-> sq_ff[SQ_STEPS].root <= LEN_MAX)
      else $error("square root out of range");

   // quotient bounded by full deflection
   a_quot_range: assert property (@(posedge clock) disable iff (reset)
      dv_vld_ff[DIV_STEPS] && !dv_ff[DIV_STEPS].in_dz && !dv_ff[DIV_STEPS].zero
      |-> dv_ff[DIV_STEPS].qx <= Q_MAX && dv_ff[DIV_STEPS].qy <= Q_MAX)
      else $error("quotient above full scale");

   // a stall freezes the pipeline contents
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !pipe_en |=> $stable(g_vld_ff) && $stable(dv_vld_ff[0]) && $stable(a_vld_ff))
      else $error("pipeline moved during stall");

endmodule
